>>> rtl/tirc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tirc_pkg
// Shared types and constants for the timed intent ring correlator.
// ============================================================================
package tirc_pkg;

    localparam int unsigned DEF_RING_DEPTH = 256;
    localparam logic [31:0] FREQ_RESET     = 32'd10000000;
    localparam logic [31:0] MS_PER_SEC     = 32'd1000;
    localparam logic [31:0] U32_MAX        = 32'hFFFF_FFFF;
    localparam logic [31:0] MS_RECIP       = 32'd274877907;
    localparam int unsigned MS_RECIP_SHIFT = 38;

    localparam logic [1:0] OP_RECORD = 2'd0;
    localparam logic [1:0] OP_PAIR   = 2'd1;
    localparam logic [1:0] OP_TARGET = 2'd2;

    typedef struct packed {
        logic [31:0] caller;
        logic [31:0] target;
        logic [31:0] mask;
        logic [31:0] flags;
        logic [62:0] stamp;
    } slot_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WMUL,
        ST_WQ1,
        ST_WQ2,
        ST_WQ3,
        ST_WSUM,
        ST_WWIN,
        ST_WLO,
        ST_SCAN,
        ST_DRAIN,
        ST_SEL,
        ST_AGE,
        ST_AGESTART,
        ST_AGEDIV,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

>>> rtl/timed_intent_ring_correlator.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// timed_intent_ring_correlator
// Ring of timestamped caller/target records with windowed correlation queries.
// ============================================================================
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | op, caller_id .. now_time
//  out     | output    | out_valid/out_stall| found, caller_out .. age_ms
//  cfg     | input     | cfg_wr_en          | cfg_wr_data (tick_frequency)
//
//  Record: written into the slot memory on the accept edge.
//  Pair query: the window is computed through one shared reciprocal
//  multiply, then every slot is scanned; on a match the bit-serial divider
//  works out the age. A target query first scans to pick a caller and,
//  if one is picked, scans again for it. A held result adds its stall.
//  Reset empties the ring through a fill count; no clearing pass.
// ============================================================================
module timed_intent_ring_correlator
    import tirc_pkg::*;
#(
    parameter int unsigned RING_DEPTH = DEF_RING_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  op,
    input  wire logic [31:0] caller_id,
    input  wire logic [31:0] target_id,
    input  wire logic [31:0] rights_mask,
    input  wire logic [31:0] intent_flags,
    input  wire logic [31:0] window_ms,
    input  wire logic        prefer_external,
    input  wire logic [62:0] now_time,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             found,
    output logic [31:0]      caller_out,
    output logic [31:0]      flags_out,
    output logic [31:0]      mask_out,
    output logic [31:0]      age_ms
);

    localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int unsigned FW = $clog2(RING_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);
    localparam logic [FW-1:0] FULL_CNT = FW'(RING_DEPTH);

    slot_t       mem [RING_DEPTH];
    slot_t       rd_data_reg;

    state_t      state_reg, state_next;
    logic [31:0] freq_reg;
    logic [AW-1:0] wp_reg;
    logic [FW-1:0] fill_reg;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] rd_idx_reg;
    logic        rd_v_reg;
    logic        pass_reg;

    logic        qtarget_reg;
    logic        pref_reg;
    logic [31:0] tgt_reg;
    logic [31:0] key_reg;
    logic [31:0] sel_reg;
    logic [31:0] wms_reg;
    logic [62:0] now_reg;
    logic [31:0] wq_reg, fq_reg;
    logic [9:0]  wr_reg, fr_reg;
    logic [63:0] p1_reg;
    logic [31:0] p2_reg;
    logic [19:0] p3_reg;
    logic [31:0] p3q_reg;
    logic [63:0] wsum_reg;
    logic [62:0] win_reg;
    logic [62:0] lo_reg;

    logic        fany_reg, fext_reg;
    logic [62:0] tany_reg, text_reg;
    logic [31:0] cany_reg, cext_reg;
    logic        hit_reg;
    logic [62:0] tbest_reg;
    logic [31:0] flags_acc_reg, mask_acc_reg;
    logic [62:0] delta_reg;
    logic [31:0] age_reg;

    logic        out_valid_reg;
    logic        found_reg;
    logic [31:0] caller_out_reg, flags_out_reg, mask_out_reg, age_out_reg;

    logic        accept;
    logic        load_out;
    logic        div_start, div_busy, div_done;
    logic [63:0] div_dividend, div_quotient;
    logic [31:0] div_divisor;
    logic [31:0] freq_eff;
    logic [AW-1:0] wp_inc;
    logic        slot_live, slot_match, slot_ext;
    logic [31:0] sel_pick;
    logic [31:0] recip_in, recip_q;
    logic [63:0] recip_prod;
    logic [63:0] win_sum;

    assign freq_eff = (freq_reg == 32'd0) ? 32'd1 : freq_reg;
    assign wp_inc   = (wp_reg == LAST_IDX) ? '0 : wp_reg + AW'(1);
    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // divide by 1000 through one shared reciprocal multiply
    assign recip_in   = (state_reg == ST_WMUL) ? wms_reg
                      : (state_reg == ST_WQ1) ? freq_eff : 32'(p3_reg);
    assign recip_prod = 64'(recip_in) * 64'(MS_RECIP);
    assign recip_q    = 32'(recip_prod >> MS_RECIP_SHIFT);
    assign win_sum    = wsum_reg + 64'(p3q_reg);

    assign slot_live  = (FW'(rd_idx_reg) < fill_reg) && (rd_data_reg.stamp != 63'd0)
                        && (rd_data_reg.stamp <= now_reg) && (rd_data_reg.stamp >= lo_reg);
    assign slot_match = slot_live && (rd_data_reg.target == tgt_reg);
    assign slot_ext   = rd_data_reg.caller != rd_data_reg.target;
    assign sel_pick   = (pref_reg && fext_reg) ? cext_reg : (fany_reg ? cany_reg : 32'd0);

    // slot memory
    always_ff @(posedge clk)
    begin
        if (accept && op == OP_RECORD)
        begin
            mem[wp_inc] <= '{caller: caller_id, target: target_id, mask: rights_mask,
                             flags: intent_flags, stamp: now_time};
        end
        rd_data_reg <= mem[idx_reg];
    end

    tirc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        state_next   = state_reg;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = freq_eff;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (op == OP_PAIR || op == OP_TARGET))
                begin
                    state_next = ST_WMUL;
                end
            end
            ST_WMUL:   state_next = ST_WQ1;
            ST_WQ1:    state_next = ST_WQ2;
            ST_WQ2:    state_next = ST_WQ3;
            ST_WQ3:    state_next = ST_WSUM;
            ST_WSUM:   state_next = ST_WWIN;
            ST_WWIN:   state_next = ST_WLO;
            ST_WLO:    state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_SEL;
            ST_SEL:
            begin
                if (!pass_reg)
                begin
                    state_next = (sel_pick == 32'd0) ? ST_DONE : ST_SCAN;
                end
                else
                begin
                    state_next = hit_reg ? ST_AGE : ST_DONE;
                end
            end
            ST_AGE:    state_next = ST_AGESTART;
            ST_AGESTART:
            begin
                div_start    = 1'b1;
                div_dividend = ({1'b0, delta_reg} << 10) - ({1'b0, delta_reg} << 4)
                               - ({1'b0, delta_reg} << 3);
                state_next   = ST_AGEDIV;
            end
            ST_AGEDIV:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            freq_reg      <= FREQ_RESET;
            wp_reg        <= LAST_IDX;
            fill_reg      <= '0;
            rd_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_v_reg  <= (state_reg == ST_SCAN);
            if (cfg_wr_en)
            begin
                freq_reg <= cfg_wr_data;
            end
            if (accept && op == OP_RECORD)
            begin
                wp_reg <= wp_inc;
                if (fill_reg != FULL_CNT)
                begin
                    fill_reg <= fill_reg + FW'(1);
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // query datapath
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= idx_reg;
        if (state_reg == ST_SCAN)
        begin
            idx_reg <= idx_reg + AW'(1);
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                qtarget_reg <= (op == OP_TARGET);
                pref_reg    <= prefer_external;
                tgt_reg     <= target_id;
                key_reg     <= caller_id;
                sel_reg     <= '0;
                wms_reg     <= window_ms;
                now_reg     <= now_time;
            end
            // window = (ms / 1000) * f + (ms % 1000) * (f / 1000)
            //        + ((ms % 1000) * (f % 1000)) / 1000
            ST_WMUL:   wq_reg <= recip_q;
            ST_WQ1:
            begin
                fq_reg <= recip_q;
                wr_reg <= 10'(wms_reg - wq_reg * MS_PER_SEC);
            end
            ST_WQ2:
            begin
                fr_reg <= 10'(freq_eff - fq_reg * MS_PER_SEC);
                p1_reg <= 64'(wq_reg) * 64'(freq_eff);
            end
            ST_WQ3:
            begin
                p2_reg <= 32'(wr_reg) * fq_reg;
                p3_reg <= 20'(wr_reg) * 20'(fr_reg);
            end
            ST_WSUM:
            begin
                p3q_reg  <= recip_q;
                wsum_reg <= p1_reg + 64'(p2_reg);
            end
            ST_WWIN:
            begin
                if (wms_reg == 32'd0)
                begin
                    win_reg <= '0;
                end
                else if (win_sum == 64'd0)
                begin
                    win_reg <= 63'd1;
                end
                else
                begin
                    win_reg <= win_sum[62:0];
                end
            end
            ST_WLO:
            begin
                lo_reg        <= (now_reg >= win_reg) ? now_reg - win_reg : '0;
                idx_reg       <= '0;
                pass_reg      <= !qtarget_reg;
                fany_reg      <= 1'b0;
                fext_reg      <= 1'b0;
                hit_reg       <= 1'b0;
                flags_acc_reg <= '0;
                mask_acc_reg  <= '0;
            end
            ST_SEL:
            begin
                if (!pass_reg)
                begin
                    key_reg  <= sel_pick;
                    sel_reg  <= sel_pick;
                    pass_reg <= 1'b1;
                    idx_reg  <= '0;
                end
            end
            ST_AGE:    delta_reg <= now_reg - tbest_reg;
            ST_AGEDIV:
            begin
                if (div_done)
                begin
                    age_reg <= (div_quotient[63:32] != 32'd0) ? U32_MAX : div_quotient[31:0];
                end
            end
            default:
            begin
            end
        endcase

        if (rd_v_reg && slot_match)
        begin
            if (!pass_reg)
            begin
                if (!fany_reg || rd_data_reg.stamp > tany_reg)
                begin
                    fany_reg <= 1'b1;
                    tany_reg <= rd_data_reg.stamp;
                    cany_reg <= rd_data_reg.caller;
                end
                if (slot_ext && (!fext_reg || rd_data_reg.stamp > text_reg))
                begin
                    fext_reg <= 1'b1;
                    text_reg <= rd_data_reg.stamp;
                    cext_reg <= rd_data_reg.caller;
                end
            end
            else if (rd_data_reg.caller == key_reg)
            begin
                hit_reg       <= 1'b1;
                flags_acc_reg <= flags_acc_reg | rd_data_reg.flags;
                mask_acc_reg  <= mask_acc_reg | rd_data_reg.mask;
                if (!hit_reg || rd_data_reg.stamp > tbest_reg)
                begin
                    tbest_reg <= rd_data_reg.stamp;
                end
            end
        end

        if (load_out)
        begin
            found_reg      <= hit_reg && pass_reg;
            caller_out_reg <= (hit_reg && pass_reg) ? sel_reg : '0;
            flags_out_reg  <= (hit_reg && pass_reg) ? flags_acc_reg : '0;
            mask_out_reg   <= (hit_reg && pass_reg) ? mask_acc_reg : '0;
            age_out_reg    <= (hit_reg && pass_reg) ? age_reg : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign found      = found_reg;
    assign caller_out = caller_out_reg;
    assign flags_out  = flags_out_reg;
    assign mask_out   = mask_out_reg;
    assign age_ms     = age_out_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_CNT)
        else $error("fill count beyond ring depth");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_rd_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_v_reg |-> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("slot read outside a scan");

    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("result not presented after load");

endmodule
`default_nettype wire

>>> rtl/tirc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tirc_div
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// ============================================================================
module tirc_div
    import tirc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [63:0]      quotient
);

    logic [31:0] rem_reg,  rem_next;
    logic [63:0] quo_reg,  quo_next;
    logic [31:0] dvs_reg;
    logic [5:0]  cnt_reg,  cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [32:0] diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[63]};
        diff      = trial - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[32])
            begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Checks the timed intent ring correlator against a cycle-free predictor:
// records fill a local copy of the ring, queries are answered from it and
// compared field by field with the block's results, across several tick
// frequencies and sender/receiver idling patterns.
// ============================================================================
module testbench;
    import tirc_pkg::*;

    localparam logic [1:0]  OP_NONE   = 2'd3;
    localparam logic [62:0] STAMP_MAX = {63{1'b1}};
    localparam int          DRAIN_CYC = 800;
    localparam int          HANG_CYC  = 20000;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] caller;
        logic [31:0] target;
        logic [31:0] mask;
        logic [31:0] flags;
        logic [31:0] win_ms;
        logic        pref;
        logic [62:0] now;
    } item_t;

    typedef struct packed {
        logic        found;
        logic [31:0] caller;
        logic [31:0] flags;
        logic [31:0] mask;
        logic [31:0] age;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        in_valid;
    logic        in_stall;
    item_t       drv;
    logic        out_valid;
    logic        out_stall;
    answer_t     got;

    timed_intent_ring_correlator dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(drv.op), .caller_id(drv.caller), .target_id(drv.target),
        .rights_mask(drv.mask), .intent_flags(drv.flags),
        .window_ms(drv.win_ms), .prefer_external(drv.pref), .now_time(drv.now),
        .out_valid(out_valid), .out_stall(out_stall),
        .found(got.found), .caller_out(got.caller), .flags_out(got.flags),
        .mask_out(got.mask), .age_ms(got.age)
    );

    // local copy of the ring
    logic [31:0] ring_caller [256];
    logic [31:0] ring_target [256];
    logic [31:0] ring_mask   [256];
    logic [31:0] ring_flags  [256];
    logic [62:0] ring_stamp  [256];
    logic [7:0]  ring_wr;
    logic [31:0] tick_freq;

    item_t   item_queue[$];
    answer_t expected_answers[$];
    int      errors = 0;
    int      send_idle = 13;
    int      recv_idle = 74;
    int      hang_count = 0;

    logic [62:0] stamp_base;
    logic [31:0] targets [4];
    logic [31:0] callers [4];

    always #5 clk = ~clk;

    function automatic logic [63:0] eff_freq();
        return (tick_freq == 0) ? 64'd1 : 64'(tick_freq);
    endfunction

    function automatic logic [63:0] window_ticks(input logic [31:0] ms);
        logic [63:0] t;
        t = (64'(ms) * eff_freq()) / 64'd1000;
        if (ms == 0)
            return 64'd0;
        return (t == 0) ? 64'd1 : t;
    endfunction

    function automatic logic [31:0] age_of(input logic [63:0] delta);
        logic [63:0] q;
        q = (delta * 64'd1000) / eff_freq();
        return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    function automatic logic live(input int i, input logic [62:0] now,
                                  input logic [63:0] win, output logic [63:0] d);
        d = 64'(now) - 64'(ring_stamp[i]);
        return ring_stamp[i] != 0 && now >= ring_stamp[i] && d <= win;
    endfunction

    task automatic answer_item(input item_t it);
        answer_t     a;
        logic [63:0] win, d, best, bany, bext;
        logic [31:0] who, cany, cext;
        logic        fany, fext, hit;
        if (it.op == OP_RECORD) begin
            ring_wr = ring_wr + 8'd1;
            ring_caller[ring_wr] = it.caller;
            ring_target[ring_wr] = it.target;
            ring_mask[ring_wr]   = it.mask;
            ring_flags[ring_wr]  = it.flags;
            ring_stamp[ring_wr]  = it.now;
            return;
        end
        if (it.op == OP_NONE)
            return;
        win  = window_ticks(it.win_ms);
        a    = '0;
        who  = it.caller;
        best = 64'(STAMP_MAX);
        hit  = 0;
        if (it.op == OP_TARGET) begin
            bany = 64'(STAMP_MAX);
            bext = 64'(STAMP_MAX);
            cany = 0; cext = 0; fany = 0; fext = 0;
            for (int i = 0; i < 256; i++) begin
                if (ring_target[i] == it.target && live(i, it.now, win, d)) begin
                    if (d < bany) begin bany = d; cany = ring_caller[i]; fany = 1; end
                    if (ring_caller[i] != ring_target[i] && d < bext) begin
                        bext = d; cext = ring_caller[i]; fext = 1;
                    end
                end
            end
            who = (it.pref && fext) ? cext : (fany ? cany : 32'd0);
        end
        if (!(it.op == OP_TARGET && who == 0)) begin
            for (int i = 0; i < 256; i++) begin
                if (ring_target[i] == it.target && ring_caller[i] == who
                        && live(i, it.now, win, d)) begin
                    hit = 1;
                    a.flags |= ring_flags[i];
                    a.mask  |= ring_mask[i];
                    if (d < best)
                        best = d;
                end
            end
        end
        if (hit) begin
            a.found  = 1;
            a.caller = (it.op == OP_TARGET) ? who : 32'd0;
            a.age    = age_of(best);
        end
        else
            a = '0;
        expected_answers.push_back(a);
    endtask

    // driver
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                answer_item(drv);
            if (!in_valid || !in_stall) begin
                if (item_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
                    drv      <= item_queue.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and watchdog
    always @(posedge clk) begin
        answer_t e;
        if (rst_n) begin
            out_stall <= ($urandom_range(99) < recv_idle);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                    (item_queue.size() == 0 && expected_answers.size() == 0))
                hang_count <= 0;
            else
                hang_count <= hang_count + 1;
            if (hang_count >= HANG_CYC) begin
                $display("end of test: mismatches");
                $finish;
            end
            if (out_valid && !out_stall) begin
                if (expected_answers.size() == 0) begin
                    errors <= errors + 1;
                    $display("%0t: unexpected result found=%b caller=%h flags=%h mask=%h age=%h",
                             $time, got.found, got.caller, got.flags, got.mask, got.age);
                end
                else begin
                    e = expected_answers.pop_front();
                    if (got !== e) begin
                        errors <= errors + 1;
                        $display("%0t: expected found=%b caller=%h flags=%h mask=%h age=%h",
                                 $time, e.found, e.caller, e.flags, e.mask, e.age);
                        $display("%0t:   actual found=%b caller=%h flags=%h mask=%h age=%h",
                                 $time, got.found, got.caller, got.flags, got.mask, got.age);
                    end
                end
            end
        end
    end

    function automatic item_t mk(input logic [1:0] op, input logic [31:0] c,
                                 input logic [31:0] t, input logic [31:0] ms,
                                 input logic pref, input logic [62:0] now);
        item_t it;
        it.op = op; it.caller = c; it.target = t;
        it.mask = $urandom; it.flags = $urandom;
        it.win_ms = ms; it.pref = pref; it.now = now;
        return it;
    endfunction

    task automatic new_pools();
        stamp_base = {1'b0, $urandom_range(0, 1) ? 30'd0 : 30'($urandom), 32'($urandom)};
        for (int i = 0; i < 4; i++) begin
            targets[i] = $urandom;
            callers[i] = $urandom;
        end
        callers[0] = 0;
    endtask

    task automatic push_random(input int n);
        item_t       it;
        logic [31:0] t, c, ms;
        logic [62:0] now;
        int          r;
        for (int k = 0; k < n; k++) begin
            t = ($urandom_range(19) == 0) ? 32'($urandom) : targets[$urandom_range(3)];
            case ($urandom_range(5))
                0: c = t;
                1: c = $urandom;
                default: c = callers[$urandom_range(3)];
            endcase
            case ($urandom_range(6))
                0: ms = 0;
                1: ms = 1;
                2: ms = 32'hFFFF_FFFF;
                3: ms = $urandom;
                default: ms = $urandom_range(0, 5000);
            endcase
            r = $urandom_range(99);
            if (r < 45) begin
                stamp_base = stamp_base + 63'($urandom_range(0, 5000));
                item_queue.push_back(mk(OP_RECORD, c, t, ms, 1'($urandom_range(1)),
                                        stamp_base));
            end
            else begin
                case ($urandom_range(7))
                    0: now = stamp_base;
                    1: now = stamp_base - 63'($urandom_range(1, 3000));
                    2: now = stamp_base + 63'($urandom);
                    default: now = stamp_base + 63'($urandom_range(0, 20000));
                endcase
                it = mk((r < 70) ? OP_PAIR : (r < 95) ? OP_TARGET : OP_NONE,
                        c, t, ms, 1'($urandom_range(1)), now);
                item_queue.push_back(it);
            end
        end
    endtask

    task automatic wait_quiet();
        while (item_queue.size() != 0 || in_valid || expected_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        while (in_valid || in_stall || expected_answers.size() != 0)
            @(posedge clk);
    endtask

    task automatic settle_and_set_freq(input logic [31:0] v);
        wait_quiet();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        tick_freq   = v;
    endtask

    initial begin
        clk = 0; rst_n = 0;
        cfg_wr_en = 0; cfg_wr_data = 0;
        in_valid = 0; out_stall = 0; drv = '0;
        for (int i = 0; i < 256; i++) begin
            ring_caller[i] = 0; ring_target[i] = 0; ring_mask[i] = 0;
            ring_flags[i] = 0; ring_stamp[i] = 0;
        end
        ring_wr = 8'hFF;
        tick_freq = FREQ_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        settle_and_set_freq(32'd1000);

        // directed: empty slot, zero-width window, ties, self and zero callers,
        // future records, top of the time range, unused op
        item_queue.push_back(mk(OP_RECORD, 32'h22, 32'h11, 0, 0, 63'd0));
        item_queue.push_back(mk(OP_PAIR,   32'h22, 32'h11, 32'hFFFF_FFFF, 0, 63'd50));
        item_queue.push_back(mk(OP_RECORD, 32'h22, 32'h11, 0, 0, 63'd100));
        item_queue.push_back(mk(OP_RECORD, 32'h11, 32'h11, 0, 0, 63'd100));
        item_queue.push_back(mk(OP_RECORD, 32'hFFFF_FFFF, 32'h11, 0, 0, 63'd100));
        item_queue.push_back(mk(OP_RECORD, 32'h22, 32'h11, 0, 0, 63'd5000));
        item_queue.push_back(mk(OP_PAIR,   32'h22, 32'h11, 0, 0, 63'd100));
        item_queue.push_back(mk(OP_PAIR,   32'h22, 32'h11, 1, 0, 63'd102));
        item_queue.push_back(mk(OP_PAIR,   32'h22, 32'h11, 1, 0, 63'd101));
        item_queue.push_back(mk(OP_TARGET, 0, 32'h11, 10, 0, 63'd105));
        item_queue.push_back(mk(OP_TARGET, 0, 32'h11, 10, 1, 63'd105));
        item_queue.push_back(mk(OP_RECORD, 32'h0, 32'h33, 0, 0, 63'd200));
        item_queue.push_back(mk(OP_RECORD, 32'h44, 32'h33, 0, 0, 63'd150));
        item_queue.push_back(mk(OP_TARGET, 0, 32'h33, 100, 0, 63'd200));
        item_queue.push_back(mk(OP_TARGET, 0, 32'h33, 100, 1, 63'd200));
        item_queue.push_back(mk(OP_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, STAMP_MAX));
        item_queue.push_back(mk(OP_TARGET, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, STAMP_MAX));
        item_queue.push_back(mk(OP_PAIR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                                STAMP_MAX));
        item_queue.push_back(mk(OP_NONE, 32'h22, 32'h11, 32'hFFFF_FFFF, 1, 63'd5000));
        item_queue.push_back(mk(OP_PAIR, 32'h22, 32'h11, 32'hFFFF_FFFF, 0, STAMP_MAX));

        new_pools();
        push_random(170);
        settle_and_set_freq(32'd1);
        new_pools();
        push_random(170);
        settle_and_set_freq(32'd0);
        send_idle = 74; recv_idle = 13;
        new_pools();
        push_random(165);
        settle_and_set_freq(32'hFFFF_FFFF);
        new_pools();
        push_random(165);
        settle_and_set_freq(FREQ_RESET);
        send_idle = 0; recv_idle = 0;
        new_pools();
        push_random(165);
        settle_and_set_freq(32'd12345);
        new_pools();
        push_random(165);

        wait_quiet();
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
